@@ hdl/cfc_pkg.sv @@
`default_nettype none

package cfc_pkg;

    // field widths of the item and result
    localparam int ACTION_W   = 2;
    localparam int HEIGHT_W   = 6;
    localparam int MATERIAL_W = 8;
    localparam int DIR_W      = 2;

    // tallest height a span may name, larger heights saturate to it
    localparam int COLUMN_HEIGHT = 32;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [ACTION_W-1:0] {
        ACT_OPEN  = 2'd0,
        ACT_SPAN  = 2'd1,
        ACT_CLOSE = 2'd2
    } t_action;

    // classified item as queued for the back end
    typedef struct packed {
        t_action                 op;
        logic [HEIGHT_W-1:0]     bottom;
        logic [HEIGHT_W-1:0]     top;
        logic [MATERIAL_W-1:0]   material;
        logic [DIR_W-1:0]        direction;
    } t_cmd;

    // saturate a height to the column height
    function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] h);
        return (h > HEIGHT_W'(COLUMN_HEIGHT)) ? HEIGHT_W'(COLUMN_HEIGHT) : h;
    endfunction

endpackage

`default_nettype wire

@@ hdl/cfc_if.sv @@
`default_nettype none

// input channel: one span or control item per transfer
interface cfc_in_if
    import cfc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [HEIGHT_W-1:0]   span_bottom;
    logic [HEIGHT_W-1:0]   span_top;
    logic [MATERIAL_W-1:0] material;
    logic [DIR_W-1:0]      direction;

    modport source (
        output valid, action, span_bottom, span_top, material, direction,
        input  ready
    );
    modport sink (
        input  valid, action, span_bottom, span_top, material, direction,
        output ready
    );
endinterface

// output channel: one face interval or run end per transfer
interface cfc_out_if
    import cfc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [HEIGHT_W-1:0]   face_bottom;
    logic [HEIGHT_W-1:0]   face_top;
    logic [MATERIAL_W-1:0] face_material;
    logic [DIR_W-1:0]      face_direction;
    logic                  face_valid;
    logic                  run_end;

    modport source (
        output valid, face_bottom, face_top, face_material, face_direction,
               face_valid, run_end,
        input  ready
    );
    modport sink (
        input  valid, face_bottom, face_top, face_material, face_direction,
               face_valid, run_end,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/column_face_culling.sv @@
// path: an accepted item is written into the command queue, then passes from the queue
//   into the output register, from which it transfers
// throughput: one item per cycle while the output is not stalled (combinational span unit)
// stalls: while the output is stalled the four-entry queue takes up to four more items;
//   items dropped at the front (empty or inverted spans, spare action) also wait for room
// reset: synchronous active-low i_rst_n clears span state, queue and output valid
`default_nettype none

module column_face_culling
    import cfc_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    cfc_in_if.sink    i_in,
    cfc_out_if.source o_out
);

    logic push;
    t_cmd push_cmd;
    logic full;
    logic cmd_valid;
    t_cmd cmd;
    logic pop;

    // decode and saturate incoming items
    cfc_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    // decouple front and back
    cfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_data  (cmd),
        .i_pop   (pop)
    );

    // span state and face emission
    cfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

@@ hdl/cfc_front.sv @@
`default_nettype none

module cfc_front
    import cfc_pkg::*;
(
    cfc_in_if.sink   i_in,
    input  wire      i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic                keep;
    logic [HEIGHT_W-1:0] bottom_c;
    logic [HEIGHT_W-1:0] top_c;
    t_action             op;

    // saturate heights and decode the action
    always_comb begin
        bottom_c = clamp_height(i_in.span_bottom);
        top_c    = clamp_height(i_in.span_top);
        op       = t_action'(i_in.action);
        keep     = 1'b0;
        case (op)
            ACT_OPEN:  keep = 1'b1;
            ACT_CLOSE: keep = 1'b1;
            // empty or inverted spans never change state
            ACT_SPAN:  keep = (bottom_c < top_c);
            default:   keep = 1'b0;
        endcase
    end

    // take items whenever the queue has room, drop the ones with no effect
    assign i_in.ready = ~i_full;
    assign o_push     = i_in.valid & ~i_full & keep;

    assign o_cmd.op        = op;
    assign o_cmd.bottom    = bottom_c;
    assign o_cmd.top       = top_c;
    assign o_cmd.material  = i_in.material;
    assign o_cmd.direction = i_in.direction;

endmodule

`default_nettype wire

@@ hdl/cfc_queue.sv @@
`default_nettype none

module cfc_queue
    import cfc_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_push,
    input  t_cmd     i_data,
    output logic     o_full,
    output logic     o_valid,
    output t_cmd     o_data,
    input  wire      i_pop
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (!do_push && do_pop) r_count <= r_count - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("command queue count beyond depth");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full command queue");
`endif

endmodule

`default_nettype wire

@@ hdl/cfc_back.sv @@
`default_nettype none

module cfc_back
    import cfc_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_cmd_valid,
    input  t_cmd     i_cmd,
    output logic     o_pop,
    cfc_out_if.source o_out
);

    // block span state
    logic [HEIGHT_W-1:0]   r_top,   n_top;
    logic [MATERIAL_W-1:0] r_mat,   n_mat;
    logic [DIR_W-1:0]      r_dir,   n_dir;
    logic [HEIGHT_W-1:0]   r_slide, n_slide;
    logic                  r_done,  n_done;

    // output register
    logic                  r_out_valid;
    logic [HEIGHT_W-1:0]   r_face_bottom;
    logic [HEIGHT_W-1:0]   r_face_top;
    logic [MATERIAL_W-1:0] r_face_material;
    logic [DIR_W-1:0]      r_face_direction;
    logic                  r_face_valid;
    logic                  r_run_end;

    logic                  emit;
    logic [HEIGHT_W-1:0]   e_bottom;
    logic [HEIGHT_W-1:0]   e_top;
    logic [MATERIAL_W-1:0] e_mat;
    logic [DIR_W-1:0]      e_dir;
    logic                  e_valid;
    logic                  e_end;

    // take the next command when the output slot is free or draining
    assign o_pop = i_cmd_valid & (~r_out_valid | o_out.ready);

    // execute one command
    always_comb begin
        n_top    = r_top;
        n_mat    = r_mat;
        n_dir    = r_dir;
        n_slide  = r_slide;
        n_done   = r_done;
        emit     = 1'b0;
        e_bottom = '0;
        e_top    = '0;
        e_mat    = '0;
        e_dir    = '0;
        e_valid  = 1'b0;
        e_end    = 1'b0;
        case (i_cmd.op)
            ACT_OPEN: begin
                n_top   = i_cmd.top;
                n_mat   = i_cmd.material;
                n_dir   = i_cmd.direction;
                n_slide = i_cmd.bottom;
                n_done  = 1'b0;
            end
            ACT_SPAN: begin
                if (!r_done) begin
                    if (i_cmd.bottom < r_top && i_cmd.top > r_slide) begin
                        // gap below this neighbour span
                        if (r_slide < i_cmd.bottom) begin
                            emit     = 1'b1;
                            e_bottom = r_slide;
                            e_top    = i_cmd.bottom;
                            e_mat    = r_mat;
                            e_dir    = r_dir;
                            e_valid  = 1'b1;
                        end
                        if (i_cmd.top < r_top) begin
                            n_slide = i_cmd.top;
                        end else begin
                            n_slide = r_top;
                            n_done  = 1'b1;
                        end
                    end else if (i_cmd.bottom > r_top) begin
                        n_done = 1'b1;
                    end
                end
            end
            ACT_CLOSE: begin
                emit  = 1'b1;
                e_end = 1'b1;
                if (r_slide < r_top) begin
                    e_bottom = r_slide;
                    e_top    = r_top;
                    e_mat    = r_mat;
                    e_dir    = r_dir;
                    e_valid  = 1'b1;
                    n_slide  = r_top;
                end
                n_done = 1'b1;
            end
            default: begin
                n_done = r_done;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_mat   <= '0;
            r_dir   <= '0;
            r_slide <= '0;
            r_done  <= 1'b0;
        end else if (o_pop) begin
            r_top   <= n_top;
            r_mat   <= n_mat;
            r_dir   <= n_dir;
            r_slide <= n_slide;
            r_done  <= n_done;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_face_bottom    <= e_bottom;
            r_face_top       <= e_top;
            r_face_material  <= e_mat;
            r_face_direction <= e_dir;
            r_face_valid     <= e_valid;
            r_run_end        <= e_end;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.face_bottom    = r_face_bottom;
    assign o_out.face_top       = r_face_top;
    assign o_out.face_material  = r_face_material;
    assign o_out.face_direction = r_face_direction;
    assign o_out.face_valid     = r_face_valid;
    assign o_out.run_end        = r_run_end;

`ifndef SYNTHESIS
    a_face_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_face_valid |-> r_face_bottom < r_face_top)
        else $error("emitted face interval is empty");

    a_close_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_cmd.op == ACT_CLOSE |=> r_done)
        else $error("scan not marked done after close");

    a_slide_in_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slide <= HEIGHT_W'(COLUMN_HEIGHT))
        else $error("sliding height above column");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench
    import cfc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // action code the block leaves unused
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 650;

    typedef struct {
        logic [ACTION_W-1:0]   action;
        logic [HEIGHT_W-1:0]   bottom;
        logic [HEIGHT_W-1:0]   top;
        logic [MATERIAL_W-1:0] material;
        logic [DIR_W-1:0]      direction;
    } t_span_item;

    typedef struct {
        logic [HEIGHT_W-1:0]   bottom;
        logic [HEIGHT_W-1:0]   top;
        logic [MATERIAL_W-1:0] material;
        logic [DIR_W-1:0]      direction;
        logic                  valid;
        logic                  run_end;
    } t_face;

    // tracks the open block span and the faces it still owes
    class face_scoreboard;
        logic [HEIGHT_W-1:0]   blk_top      = '0;
        logic [MATERIAL_W-1:0] blk_material = '0;
        logic [DIR_W-1:0]      blk_dir      = '0;
        logic [HEIGHT_W-1:0]   slide        = '0;
        bit                    covered      = 1'b0;
        t_face                 faces_due[$];
        int                    errors       = 0;

        function logic [HEIGHT_W-1:0] saturate(logic [HEIGHT_W-1:0] h);
            if (h > COLUMN_HEIGHT)
                return HEIGHT_W'(COLUMN_HEIGHT);
            return h;
        endfunction

        function void push_face(logic [HEIGHT_W-1:0] lo, logic [HEIGHT_W-1:0] hi,
                                logic [MATERIAL_W-1:0] mat, logic [DIR_W-1:0] dir,
                                logic vld, logic last);
            t_face f;
            f.bottom    = lo;
            f.top       = hi;
            f.material  = mat;
            f.direction = dir;
            f.valid     = vld;
            f.run_end   = last;
            faces_due = {faces_due, f};
        endfunction

        // advance the column state by one accepted item
        function void note_item(t_span_item it);
            logic [HEIGHT_W-1:0] b;
            logic [HEIGHT_W-1:0] t;
            b = saturate(it.bottom);
            t = saturate(it.top);
            case (it.action)
                ACT_OPEN: begin
                    blk_top      = t;
                    blk_material = it.material;
                    blk_dir      = it.direction;
                    slide        = b;
                    covered      = 1'b0;
                end
                ACT_SPAN: begin
                    if (!covered && b < t) begin
                        if (b < blk_top && t > slide) begin
                            // gap below this span is visible
                            if (slide < b)
                                push_face(slide, b, blk_material, blk_dir, 1'b1, 1'b0);
                            if (t < blk_top) begin
                                slide = t;
                            end else begin
                                slide   = blk_top;
                                covered = 1'b1;
                            end
                        end else if (b > blk_top) begin
                            covered = 1'b1;
                        end
                    end
                end
                ACT_CLOSE: begin
                    if (slide < blk_top) begin
                        push_face(slide, blk_top, blk_material, blk_dir, 1'b1, 1'b1);
                        slide = blk_top;
                    end else begin
                        push_face('0, '0, '0, '0, 1'b0, 1'b1);
                    end
                    covered = 1'b1;
                end
                default: ;
            endcase
        endfunction

        // compare one transferred result with the oldest face due
        function void check_face(t_face got);
            t_face want;
            if (faces_due.size() == 0) begin
                $display("%0t: expected no result, actual bottom %0d top %0d valid %0b run_end %0b",
                         $time, got.bottom, got.top, got.valid, got.run_end);
                errors++;
                return;
            end
            want = faces_due.pop_front();
            if (got.bottom !== want.bottom) begin
                $display("%0t: face_bottom expected %0d actual %0d",
                         $time, want.bottom, got.bottom);
                errors++;
            end
            if (got.top !== want.top) begin
                $display("%0t: face_top expected %0d actual %0d", $time, want.top, got.top);
                errors++;
            end
            if (got.material !== want.material) begin
                $display("%0t: face_material expected %0h actual %0h",
                         $time, want.material, got.material);
                errors++;
            end
            if (got.direction !== want.direction) begin
                $display("%0t: face_direction expected %0d actual %0d",
                         $time, want.direction, got.direction);
                errors++;
            end
            if (got.valid !== want.valid) begin
                $display("%0t: face_valid expected %0b actual %0b",
                         $time, want.valid, got.valid);
                errors++;
            end
            if (got.run_end !== want.run_end) begin
                $display("%0t: run_end expected %0b actual %0b",
                         $time, want.run_end, got.run_end);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    int   items_sent;

    face_scoreboard sb = new();

    cfc_in_if  in_if();
    cfc_out_if out_if();

    column_face_culling u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // 8 ns clock
    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // idle cycles before a transfer, none during steady stretches
    function int draw_wait();
        if (steady)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    // mostly heights up to 34, just past the column, sometimes anything up to 63
    function logic [HEIGHT_W-1:0] rand_height();
        if ($urandom_range(0, 9) == 0)
            return HEIGHT_W'($urandom_range(0, 63));
        return HEIGHT_W'($urandom_range(0, 34));
    endfunction

    // drive one item and wait for its transfer
    task automatic send_item(logic [ACTION_W-1:0] act, logic [HEIGHT_W-1:0] b,
                             logic [HEIGHT_W-1:0] t, logic [MATERIAL_W-1:0] mat,
                             logic [DIR_W-1:0] dir);
        t_span_item it;
        int         gap;
        gap = draw_wait();
        it.action    = act;
        it.bottom    = b;
        it.top       = t;
        it.material  = mat;
        it.direction = dir;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.action      <= act;
        in_if.span_bottom <= b;
        in_if.span_top    <= t;
        in_if.material    <= mat;
        in_if.direction   <= dir;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic send_span(logic [HEIGHT_W-1:0] b, logic [HEIGHT_W-1:0] t);
        send_item(ACT_SPAN, b, t, MATERIAL_W'($urandom), DIR_W'($urandom));
    endtask

    task automatic send_close();
        send_item(ACT_CLOSE, HEIGHT_W'($urandom), HEIGHT_W'($urandom),
                  MATERIAL_W'($urandom), DIR_W'($urandom));
    endtask

    // one block span with ascending neighbour spans and a close, sometimes a second close
    task automatic send_run();
        int                  h;
        int                  n;
        int                  b;
        int                  t;
        logic [HEIGHT_W-1:0] blk_b;
        logic [HEIGHT_W-1:0] blk_t;
        blk_b = HEIGHT_W'($urandom_range(0, 30));
        if ($urandom_range(0, 7) == 0)
            blk_t = rand_height();
        else
            blk_t = HEIGHT_W'($urandom_range(blk_b + 1, 34));
        send_item(ACT_OPEN, blk_b, blk_t, MATERIAL_W'($urandom), DIR_W'($urandom));
        h = $urandom_range(0, 12);
        n = $urandom_range(0, 7);
        for (int i = 0; i < n; i++) begin
            b = h + $urandom_range(0, 5);
            t = b + $urandom_range(0, 8);
            if (t > 63)
                break;
            // now and then an inverted span
            if ($urandom_range(0, 11) == 0)
                send_span(HEIGHT_W'(t), HEIGHT_W'(b));
            else
                send_span(HEIGHT_W'(b), HEIGHT_W'(t));
            h = t;
        end
        send_close();
        if ($urandom_range(0, 9) == 0)
            send_close();
    endtask

    // result side: random stalls, check every transfer
    initial begin
        t_face got;
        int    stall;
        out_if.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge clk); while (out_if.valid !== 1'b1);
            got.bottom    = out_if.face_bottom;
            got.top       = out_if.face_top;
            got.material  = out_if.face_material;
            got.direction = out_if.face_direction;
            got.valid     = out_if.face_valid;
            got.run_end   = out_if.run_end;
            sb.check_face(got);
        end
    end

    // stimulus
    initial begin
        int limit;
        rst_n             <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.action      <= '0;
        in_if.span_bottom <= '0;
        in_if.span_top    <= '0;
        in_if.material    <= '0;
        in_if.direction   <= '0;
        steady     = 1'b0;
        items_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // items before any open act on an empty span at zero
        send_span(6'd0, 6'd5);
        send_close();
        // full column, gaps, inverted and saturated spans
        send_item(ACT_OPEN, 6'd0, 6'd32, 8'hff, 2'd3);
        send_span(6'd0, 6'd4);
        send_span(6'd8, 6'd12);
        send_span(6'd10, 6'd9);
        send_span(6'd40, 6'd63);
        send_close();
        // repeated close and span after close
        send_close();
        send_span(6'd1, 6'd2);
        // span below the block, then full cover
        send_item(ACT_OPEN, 6'd5, 6'd20, 8'h00, 2'd0);
        send_span(6'd0, 6'd3);
        send_span(6'd2, 6'd8);
        send_span(6'd10, 6'd25);
        send_span(6'd21, 6'd30);
        send_close();
        // empty and inverted block spans
        send_item(ACT_OPEN, 6'd10, 6'd10, 8'h81, 2'd1);
        send_span(6'd5, 6'd15);
        send_close();
        send_item(ACT_OPEN, 6'd20, 6'd8, 8'h3c, 2'd2);
        send_close();
        // span wholly above the block ends the scan
        send_item(ACT_OPEN, 6'd4, 6'd12, 8'h5a, 2'd1);
        send_span(6'd20, 6'd25);
        send_span(6'd5, 6'd6);
        send_close();
        // saturated block top and the spare action code
        send_item(ACT_OPEN, 6'd0, 6'd63, 8'ha5, 2'd2);
        send_item(ACT_SPARE, 6'd63, 6'd63, 8'hff, 2'd3);
        send_span(6'd12, 6'd12);
        send_close();

        // random runs with some noise in between
        while (items_sent < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_item(ACTION_W'($urandom), rand_height(), rand_height(),
                              MATERIAL_W'($urandom), DIR_W'($urandom));
            end else begin
                send_run();
            end
        end
        steady = 1'b0;
        in_if.valid <= 1'b0;

        // drain
        limit = 0;
        while (sb.faces_due.size() > 0 && limit < 10000) begin
            @(posedge clk);
            limit++;
        end
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.faces_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
